// ===== src/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PACK,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	typedef struct packed {
		logic start;
		logic busy;
	} rnd_ctl_t;

	function automatic logic [31:0] ror(input logic [31:0] v, input int s);
		ror = (v >> s) | (v << (32 - s));
	endfunction
endpackage
`default_nettype wire

// ===== src/sha256_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sha256_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_bytes;
	logic [2:0]  byte_count;
	logic        last;
	modport source (output valid, data_bytes, byte_count, last, input ready);
	modport sink (input valid, data_bytes, byte_count, last, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== src/sha256_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One SHA-256 round per cycle; the schedule is updated in place in sched_q.
module sha256_round (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sha256_pkg::rnd_ctl_t ctl,
	input  wire logic [31:0]         blk [16],
	input  wire logic [31:0]         hin [8],
	output logic                     done,
	output logic [31:0]              vout [8]
);
	logic [31:0] sched_q [16];
	logic [31:0] v_q [8];
	logic [6:0]  rnd_q;
	logic        run_q;
	logic [3:0]  r4;
	logic [31:0] w15, w2, s0, s1, wv, b1, ch, t1, b0, mj;

	assign r4 = rnd_q[3:0];
	always_comb begin
		w15 = sched_q[r4 + 4'd1];
		w2  = sched_q[r4 + 4'd14];
		s0  = sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3);
		s1  = sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10);
		wv  = rnd_q[6:4] != 3'd0 ? sched_q[r4] + s0 + sched_q[r4 + 4'd9] + s1 : sched_q[r4];
		b1  = sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
			^ sha256_pkg::ror(v_q[4], 25);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + b1 + ch + sha256_pkg::RC[rnd_q[5:0]] + wv;
		b0  = sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
			^ sha256_pkg::ror(v_q[0], 22);
		mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			run_q <= 1'b0;
		end else if (ctl.start) begin
			rnd_q <= '0;
			run_q <= 1'b1;
		end else if (run_q) begin
			rnd_q <= rnd_q + 7'd1;
			if (rnd_q == 7'd63) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			sched_q <= blk;
			v_q <= hin;
		end else if (run_q) begin
			sched_q[r4] <= wv;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + b0 + mj;
		end
	end

	assign done = run_q && rnd_q == 7'd63 && ctl.busy;
	assign vout = v_q;
endmodule
`default_nettype wire

// ===== src/sha256_hash_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 engine. Input channel: items of 0..4 bytes, first byte in bits
// 31:24, last marks the end of a message. Output channel: eight digest
// words, index 0 first, last_word on index 7.
// Bytes are packed one per cycle, held while a full block is compressed;
// a full 64-byte block runs 64 rounds on the shared round unit at one
// round per cycle, after the round unit is loaded, and the result is then
// folded into the chaining value. The next item is accepted once an item's
// bytes are packed and any block it fills is folded. A last item pads one
// byte per cycle up to the length field, halting while a full block is
// compressed, runs one or two compressions, then presents the words.
// ready is low while an item is at work. The output word holds while the
// receiver stalls; the next word follows once it is taken.
// Reset restores the initial chaining value and clears length and fill.
module sha256_hash_engine_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sha256_in_if.sink    in_ch,
	sha256_out_if.source out_ch
);
	sha256_pkg::state_t st_q, st_d;
	logic [31:0] h_q [8];
	logic [31:0] blk_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] data_q;
	logic [2:0]  cnt_q;
	logic        fin_q, padded_q;
	logic [2:0]  widx_q;
	logic        done;
	logic [31:0] vout [8];
	sha256_pkg::rnd_ctl_t ctl;
	logic        put, put_pad, pad_len;
	logic [7:0]  pbyte;
	// length words sit in the block when padding reached the final block
	logic        lenblk_q;
	logic        start_q, go_rnd;

	sha256_round u_round (.clk, .arst_n, .ctl, .blk(blk_q), .hin(h_q), .done, .vout);

	always_comb begin
		st_d = st_q;
		go_rnd = 1'b0;
		ctl.start = start_q;
		ctl.busy = st_q == sha256_pkg::ST_ROUND;
		put = 1'b0; put_pad = 1'b0; pad_len = 1'b0;
		pbyte = data_q[31:24];
		unique case (st_q)
			sha256_pkg::ST_IDLE: if (in_ch.valid) st_d = sha256_pkg::ST_PACK;
			sha256_pkg::ST_PACK: begin
				if (cnt_q != 3'd0) begin
					put = 1'b1;
					if (fill_q == 6'd63) begin
						go_rnd = 1'b1;
						st_d = sha256_pkg::ST_ROUND;
					end
				end else if (fin_q) st_d = sha256_pkg::ST_PAD;
				else st_d = sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_PAD: begin
				put_pad = 1'b1;
				pbyte = padded_q ? 8'h00 : sha256_pkg::PAD_BYTE;
				if (fill_q == 6'd55) begin
					pad_len = 1'b1;
					go_rnd = 1'b1;
					st_d = sha256_pkg::ST_ROUND;
				end
				if (fill_q == 6'd63) begin
					go_rnd = 1'b1;
					st_d = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_ROUND: if (done) st_d = sha256_pkg::ST_FOLD;
			sha256_pkg::ST_FOLD: begin
				if (lenblk_q) st_d = sha256_pkg::ST_EMIT;
				else if (fin_q && cnt_q == 3'd0) st_d = sha256_pkg::ST_PAD;
				else st_d = sha256_pkg::ST_PACK;
			end
			sha256_pkg::ST_EMIT:
				if (out_ch.ready && widx_q == 3'd7) st_d = sha256_pkg::ST_IDLE;
			default: st_d = sha256_pkg::ST_IDLE;
		endcase
	end

	assign in_ch.ready = st_q == sha256_pkg::ST_IDLE;
	assign out_ch.valid = st_q == sha256_pkg::ST_EMIT;
	assign out_ch.digest_word = h_q[widx_q];
	assign out_ch.word_index = widx_q;
	assign out_ch.last_word = widx_q == 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sha256_pkg::ST_IDLE;
			h_q <= sha256_pkg::IV;
			fill_q <= '0;
			bits_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			padded_q <= 1'b0;
			lenblk_q <= 1'b0;
			widx_q <= '0;
			start_q <= 1'b0;
		end else begin
			st_q <= st_d;
			// load the round unit once the last byte of the block is in place
			start_q <= go_rnd;
			if (in_ch.valid && in_ch.ready) begin
				cnt_q <= in_ch.byte_count > 3'd4 ? 3'd4 : in_ch.byte_count;
				fin_q <= in_ch.last;
			end
			if (put) begin
				cnt_q <= cnt_q - 3'd1;
				bits_q <= bits_q + 64'd8;
			end
			if (put || put_pad) begin
				fill_q <= pad_len ? 6'd0 : fill_q + 6'd1;
				if (put_pad) padded_q <= 1'b1;
				if (pad_len) lenblk_q <= 1'b1;
			end
			if (st_q == sha256_pkg::ST_FOLD) begin
				for (int k = 0; k < 8; k++) h_q[k] <= h_q[k] + vout[k];
			end
			if (st_q == sha256_pkg::ST_EMIT && out_ch.ready) begin
				widx_q <= widx_q + 3'd1;
				if (widx_q == 3'd7) begin
					h_q <= sha256_pkg::IV;
					fill_q <= '0;
					bits_q <= '0;
					padded_q <= 1'b0;
					lenblk_q <= 1'b0;
					fin_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) data_q <= in_ch.data_bytes;
		if (put) data_q <= {data_q[23:0], 8'h00};
		if (put || put_pad) begin
			if (fill_q[1:0] == 2'd0) blk_q[fill_q[5:2]] <= {pbyte, 24'h0};
			else blk_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= pbyte;
		end
		if (pad_len) begin
			blk_q[14] <= bits_q[63:32];
			blk_q[15] <= bits_q[31:0];
		end
	end
endmodule
`default_nettype wire

// ===== src/sha256_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sha256_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [2:0] word_index,
	input wire logic last_word
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input ready while digest shown");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word mismatch");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && word_index != 3'd7) |=> (out_valid
		&& word_index == $past(word_index) + 3'd1))
		else $error("digest word skipped");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(word_index))
		else $error("stalled word changed");
endmodule

bind sha256_hash_engine_unit sha256_checker u_chk (
	.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.word_index(out_ch.word_index), .last_word(out_ch.last_word));
`default_nettype wire

// ===== tb/tb_sha256_hash_engine_unit.sv =====
`timescale 1ns / 1ps
module tb_sha256_hash_engine_unit;
	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	logic clk;
	logic arst_n;
	sha256_in_if  in_ch ();
	sha256_out_if out_ch ();

	sha256_hash_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state
	logic [31:0] hash_state [8];
	logic [31:0] msg_block [16];
	int unsigned block_fill;
	logic [63:0] bit_length;

	digest_item_t digest_queue [$];
	int  error_count;
	bit  rx_hold;
	bit  rx_gaps_on;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rotr(logic [31:0] v, int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wv;
		for (int k = 0; k < 16; k++)
			w[k] = msg_block[k];
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int r = 0; r < 64; r++) begin
			if (r >= 16) begin
				s0 = rotr(w[(r + 1) % 16], 7) ^ rotr(w[(r + 1) % 16], 18)
					^ (w[(r + 1) % 16] >> 3);
				s1 = rotr(w[(r + 14) % 16], 17) ^ rotr(w[(r + 14) % 16], 19)
					^ (w[(r + 14) % 16] >> 10);
				w[r % 16] = w[r % 16] + s0 + w[(r + 9) % 16] + s1;
			end
			wv = w[r % 16];
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ sha256_pkg::RC[r] + wv;
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endtask

	task automatic append_byte(logic [7:0] v);
		int wi;
		wi = block_fill / 4;
		if (block_fill % 4 == 0)
			msg_block[wi] = '0;
		msg_block[wi] |= 32'(v) << ((3 - block_fill % 4) * 8);
		block_fill++;
	endtask

	task automatic hash_reset();
		for (int k = 0; k < 8; k++)
			hash_state[k] = sha256_pkg::IV[k];
		block_fill = 0;
		bit_length = '0;
	endtask

	task automatic predict_digest(logic [31:0] data, logic [2:0] cnt, logic fin);
		int n;
		digest_item_t d;
		n = (cnt > 4) ? 4 : cnt;
		for (int i = 0; i < n; i++) begin
			append_byte(data[31 - 8 * i -: 8]);
			bit_length += 64'd8;
			if (block_fill == 64) begin
				compress();
				block_fill = 0;
			end
		end
		if (fin) begin
			append_byte(sha256_pkg::PAD_BYTE);
			if (block_fill > 56) begin
				while (block_fill < 64)
					append_byte(8'h00);
				compress();
				block_fill = 0;
			end
			while (block_fill < 56)
				append_byte(8'h00);
			msg_block[14] = bit_length[63:32];
			msg_block[15] = bit_length[31:0];
			compress();
			for (int k = 0; k < 8; k++) begin
				d.digest_word = hash_state[k];
				d.word_index  = 3'(k);
				d.last_word   = (k == 7);
				digest_queue.push_back(d);
			end
			hash_reset();
		end
	endtask

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
	endfunction

	bit tx_gaps_on;

	// valid stays high after an accept until the next item or a gap drops it
	task automatic send_item(logic [31:0] data, logic [2:0] cnt, logic fin);
		int g;
		g = tx_gaps_on ? gap_len() : 0;
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.data_bytes <= data;
		in_ch.byte_count <= cnt;
		in_ch.last       <= fin;
		do @(posedge clk); while (!in_ch.ready);
		predict_digest(data, cnt, fin);
	endtask

	// receiver: random stalls, plus a long hold when rx_hold is set
	initial begin
		int g;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				rx_hold = 1'b0;
			end
			g = rx_gaps_on ? gap_len() : 0;
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		digest_item_t exp_d;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (digest_queue.size() == 0) begin
				$display("%0t: unexpected digest word %h idx %0d", $time,
					out_ch.digest_word, out_ch.word_index);
				error_count++;
			end else begin
				exp_d = digest_queue.pop_front();
				if (out_ch.digest_word !== exp_d.digest_word) begin
					$display("%0t: digest_word expected %h actual %h", $time,
						exp_d.digest_word, out_ch.digest_word);
					error_count++;
				end
				if (out_ch.word_index !== exp_d.word_index) begin
					$display("%0t: word_index expected %0d actual %0d", $time,
						exp_d.word_index, out_ch.word_index);
					error_count++;
				end
				if (out_ch.last_word !== exp_d.last_word) begin
					$display("%0t: last_word expected %0d actual %0d", $time,
						exp_d.last_word, out_ch.last_word);
					error_count++;
				end
			end
		end
	end

	task automatic test_directed();
		// empty message, then "abc"
		send_item(32'h0, 3'd0, 1'b1);
		send_item(32'h616263ff, 3'd3, 1'b1);
		// oversized counts saturate; extremes of data
		send_item(32'hffffffff, 3'd7, 1'b0);
		send_item(32'h00000000, 3'd5, 1'b0);
		send_item(32'hdeadbeef, 3'd6, 1'b0);
		send_item(32'h12345678, 3'd1, 1'b0);
		send_item(32'hffffffff, 3'd2, 1'b0);
		send_item(32'h0, 3'd0, 1'b0);
		send_item(32'haaaaaaaa, 3'd4, 1'b1);
		// 56 bytes: padding spills into a second block
		for (int i = 0; i < 14; i++)
			send_item($urandom, 3'd4, i == 13);
		// exactly one block, then empty last
		for (int i = 0; i < 16; i++)
			send_item($urandom, 3'd4, 1'b0);
		send_item(32'h55555555, 3'd0, 1'b1);
	endtask

	task automatic test_random(int n_items);
		int sent, len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(1, 18);
			for (int i = 0; i < len; i++)
				send_item($urandom, 3'($urandom_range(0, 7)), i == len - 1);
			sent += len;
		end
	endtask

	task automatic test_backpressure();
		rx_hold = 1'b1;
		for (int m = 0; m < 3; m++)
			for (int i = 0; i < 5; i++)
				send_item($urandom, 3'($urandom_range(0, 4)), i == 4);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (digest_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	initial begin
		error_count = 0;
		rx_hold = 1'b0;
		rx_gaps_on = 1'b0;
		tx_gaps_on = 1'b0;
		hash_reset();
		arst_n = 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.data_bytes <= '0;
		in_ch.byte_count <= '0;
		in_ch.last       <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		drain();
		rx_gaps_on = 1'b1;
		tx_gaps_on = 1'b1;
		test_random(150);
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		test_random(100);
		rx_gaps_on = 1'b1;
		tx_gaps_on = 1'b1;
		test_random(100);
		test_backpressure();
		drain();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end
endmodule
